@@ hw/rtl/sat_pkg.sv @@
// Package for the section address translator: payload structs, action and
// register codes, and sizing constants. Depends on nothing.
package sat_pkg;

   // Table depth and index widths.
   localparam int MAX_SECTIONS = 96;
   localparam int SECT_IDX_W   = $clog2(MAX_SECTIONS);
   localparam int CNT_W        = 7;

   // Configuration port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam logic [1:0] REG_IMAGE_BASE    = 2'd0;
   localparam logic [1:0] REG_SECTION_COUNT = 2'd1;
   localparam logic [1:0] REG_BUFFER_START  = 2'd2;
   localparam logic [1:0] REG_BUFFER_LENGTH = 2'd3;

   // Request actions.
   localparam logic [2:0] ACT_LOAD     = 3'd0;
   localparam logic [2:0] ACT_FILE2VIR = 3'd1;
   localparam logic [2:0] ACT_VIR2FILE = 3'd2;
   localparam logic [2:0] ACT_VIR2IMG  = 3'd3;
   localparam logic [2:0] ACT_BUF2VIR  = 3'd4;

   typedef struct packed {
      logic [2:0]  action;
      logic [6:0]  entry_index;
      logic [31:0] raw_start;
      logic [31:0] raw_size;
      logic [31:0] virt_start;
      logic [63:0] query_address;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [63:0] result_address;
      logic [6:0]  section_index;
   } rsp_type;

   // One stored section entry.
   typedef struct packed {
      logic [31:0] raw_start;
      logic [31:0] raw_size;
      logic [31:0] virt_start;
   } sect_entry_type;

endpackage

@@ hw/rtl/sat_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the section table.
module sat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ hw/rtl/section_address_translator.sv @@
// Section address translator top level: configuration registers, section
// table RAM and the scan sequencer. Depends on sat_pkg and sat_ram.
//
//   Channel   Direction  Handshake                       Carries
//   req_*     in         req_valid / req_ready           req_type request
//   rsp_*     out        rsp_valid / rsp_ready           rsp_type result
//   APB       in/out     psel, penable, pwrite, pready   configuration registers
//
// A load or a direct translation passes from the prep state straight to the
// done state. A table search steps through the entries until a hit or the
// last searched entry: the RAM read port delivers one entry per cycle and one
// shared range comparator checks it. A hit adds a finish state that forms the
// result address. The sequencer is ready for the next request once the result
// reaches the output register. Reset clears the sequencer and the registers;
// the table needs no clearing pass. One request is in work at a time; a result
// waits in the output register while the next request enters, and a later
// result holds the sequencer until it is taken.
module section_address_translator
   import sat_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PREP   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_FINISH = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [63:0]      image_base_ff;
   logic [CNT_W-1:0] section_count_ff;
   logic [63:0]      buffer_start_ff;
   logic [31:0]      buffer_length_ff;

   logic [2:0]            state_ff, state_in;
   req_type               req_ff;
   logic [63:0]           key_ff, key_in;
   logic                  is_virt_ff, is_virt_in;
   logic [SECT_IDX_W-1:0] scan_ff, scan_in;
   logic [SECT_IDX_W-1:0] chk_ff, chk_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic [63:0]           diff_ff, diff_in;
   logic [31:0]           add_ff, add_in;
   rsp_type               res_ff, res_in;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  req_fire;
   logic                  csr_write;
   logic [CNT_W-1:0]      limit;
   logic [SECT_IDX_W-1:0] last_idx;
   sect_entry_type        wr_entry;
   sect_entry_type        rd_entry;
   logic                  load_en;
   logic [31:0]           cmp_lo;
   logic [32:0]           cmp_hi;
   logic                  cmp_hit;
   logic [63:0]           buf_off;
   logic [63:0]           img_off;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         image_base_ff    <= '0;
         section_count_ff <= '0;
         buffer_start_ff  <= '0;
         buffer_length_ff <= '0;
      end else if (csr_write) begin
         case (paddr[4:3])
            REG_IMAGE_BASE:    image_base_ff    <= pwdata;
            REG_SECTION_COUNT: section_count_ff <= pwdata[CNT_W-1:0];
            REG_BUFFER_START:  buffer_start_ff  <= pwdata;
            REG_BUFFER_LENGTH: buffer_length_ff <= pwdata[31:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (paddr[4:3])
         REG_IMAGE_BASE:    prdata = image_base_ff;
         REG_SECTION_COUNT: prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, section_count_ff};
         REG_BUFFER_START:  prdata = buffer_start_ff;
         REG_BUFFER_LENGTH: prdata = {32'd0, buffer_length_ff};
         default:           prdata = '0;
      endcase
   end

   // Loads write the table as the request is accepted.
   assign load_en  = req_fire && (req_payload.action == ACT_LOAD) &&
                     (req_payload.entry_index < CNT_W'(MAX_SECTIONS));
   assign wr_entry = '{raw_start:  req_payload.raw_start,
                       raw_size:   req_payload.raw_size,
                       virt_start: req_payload.virt_start};

   sat_ram #(
      .WIDTH ($bits(sect_entry_type)),
      .DEPTH (MAX_SECTIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (req_payload.entry_index[SECT_IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (scan_ff),
      .rd_data (rd_entry)
   );

   // Number of entries searched, capped at the table depth.
   assign limit    = (section_count_ff > CNT_W'(MAX_SECTIONS)) ?
                     CNT_W'(MAX_SECTIONS) : section_count_ff;
   assign last_idx = SECT_IDX_W'(limit - CNT_W'(1));

   // Shared range comparator: the key must lie in [lo, lo + size], both ends
   // inclusive. Virtual searches compare against the virtual start, file
   // searches against the raw start.
   assign cmp_lo  = is_virt_ff ? rd_entry.virt_start : rd_entry.raw_start;
   assign cmp_hi  = {1'b0, cmp_lo} + {1'b0, rd_entry.raw_size};
   assign cmp_hit = ({32'd0, cmp_lo} <= key_ff) && (key_ff <= {31'd0, cmp_hi});

   // Offsets of the query from the buffer start and from the image base.
   assign buf_off = req_ff.query_address - buffer_start_ff;
   assign img_off = req_ff.query_address - image_base_ff;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      is_virt_in   = is_virt_ff;
      scan_in      = scan_ff;
      chk_in       = chk_ff;
      chk_valid_in = chk_valid_ff;
      diff_in      = diff_ff;
      add_in       = add_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_PREP;
            end
         end

         ST_PREP: begin
            // A miss reports all ones; loads and unknown actions report zero.
            res_in       = '{found: 1'b0, result_address: '1, section_index: '0};
            scan_in      = '0;
            chk_valid_in = 1'b0;
            state_in     = ST_DONE;
            case (req_ff.action)
               ACT_FILE2VIR: begin
                  key_in     = req_ff.query_address;
                  is_virt_in = 1'b0;
                  if (limit != '0) begin
                     state_in = ST_SCAN;
                  end
               end
               ACT_VIR2FILE: begin
                  // An address below the image base lies in no section.
                  key_in     = img_off;
                  is_virt_in = 1'b1;
                  if ((req_ff.query_address >= image_base_ff) && (limit != '0)) begin
                     state_in = ST_SCAN;
                  end
               end
               ACT_VIR2IMG: begin
                  res_in = '{found: 1'b1, result_address: img_off, section_index: '0};
               end
               ACT_BUF2VIR: begin
                  // The query must fall inside the buffer, end inclusive.
                  key_in     = buf_off;
                  is_virt_in = 1'b0;
                  if ((req_ff.query_address >= buffer_start_ff) &&
                      (buf_off <= {32'd0, buffer_length_ff}) && (limit != '0)) begin
                     state_in = ST_SCAN;
                  end
               end
               default: begin
                  res_in = '{found: 1'b0, result_address: '0, section_index: '0};
               end
            endcase
         end

         ST_SCAN: begin
            // Addresses run one entry ahead of the check and hold at the
            // last searched entry.
            chk_valid_in = 1'b1;
            chk_in       = scan_ff;
            if (scan_ff != last_idx) begin
               scan_in = scan_ff + SECT_IDX_W'(1);
            end
            if (chk_valid_ff) begin
               if (cmp_hit) begin
                  diff_in                = key_ff - {32'd0, cmp_lo};
                  add_in                 = is_virt_ff ? rd_entry.raw_start :
                                                        rd_entry.virt_start;
                  res_in.found           = 1'b1;
                  res_in.section_index   = 7'(chk_ff);
                  state_in               = ST_FINISH;
               end else if (chk_ff == last_idx) begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_FINISH: begin
            // File side results are rebased onto the image base.
            res_in.result_address = diff_ff + {32'd0, add_ff} +
                                    (is_virt_ff ? 64'd0 : image_base_ff);
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_payload;
      end
      key_ff     <= key_in;
      is_virt_ff <= is_virt_in;
      scan_ff    <= scan_in;
      chk_ff     <= chk_in;
      diff_ff    <= diff_in;
      add_ff     <= add_in;
      res_ff     <= res_in;
      if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
